// ===== rtl/core/utf8_label_decoder_defines.svh =====
// assertion macros used by the label decoder back end
`ifndef UTF8_LABEL_DECODER_DEFINES_SVH
`define UTF8_LABEL_DECODER_DEFINES_SVH

// checked only out of reset
`define ULD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define ULD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/uld_pkg.sv =====
// types and constants of the label decoder
package uld_pkg;

  localparam int LabelSlots = 256;
  localparam int CntW       = $clog2(LabelSlots);
  localparam logic [CntW-1:0] CntMax = CntW'(LabelSlots - 1);

  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [7:0]  ByteOpen   = 8'h5B;
  localparam logic [7:0]  ByteClose  = 8'h5D;
  localparam logic [7:0]  ByteNoLead = 8'hFE;
  localparam logic [1:0]  ContTag    = 2'b10;
  localparam logic [15:0] DigitZero  = 16'd48;
  localparam logic [31:0] CodeAt     = 32'h0000_0040;
  localparam logic [31:0] FirstMask  = 32'h0000_0040;

  typedef enum logic [1:0] {
    KIND_CODE = 2'd0,
    KIND_END  = 2'd1,
    KIND_PICT = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] code_point;
    logic [15:0] picture;
  } item_t;

endpackage

// ===== rtl/core/uld_front.sv =====
// front end: bracket tracking, picture numbers and utf-8 assembly
module uld_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     byte_i,
  output logic           wr_o,
  output uld_pkg::item_t item_o
);

  logic        in_br_q, in_br_d;
  logic [15:0] acc_q, acc_d;
  logic        exp_q, exp_d;
  logic [31:0] pv_q, pv_d;
  logic [31:0] lm_q, lm_d;

  logic [31:0] pv_n, lm_n, cp;
  logic        is_cont;

  always_comb begin
    in_br_d = in_br_q;
    acc_d   = acc_q;
    exp_d   = exp_q;
    pv_d    = pv_q;
    lm_d    = lm_q;
    wr_o    = 1'b0;
    item_o  = '{kind: uld_pkg::KIND_CODE, code_point: 32'd0, picture: 16'd0};
    is_cont = (byte_i[7:6] == uld_pkg::ContTag);
    pv_n    = 32'd0;
    lm_n    = 32'd0;
    cp      = 32'd0;
    if (in_br_q) begin
      if (byte_i == uld_pkg::ByteClose) begin
        wr_o           = 1'b1;
        item_o.kind    = uld_pkg::KIND_PICT;
        item_o.picture = acc_q;
        in_br_d        = 1'b0;
        acc_d          = 16'd0;
      end else begin
        acc_d = (acc_q << 3) + (acc_q << 1) + {8'd0, byte_i} - uld_pkg::DigitZero;
      end
    end else if (byte_i == uld_pkg::ByteOpen) begin
      in_br_d = 1'b1;
    end else if ((exp_q && !is_cont) ||
                 (!exp_q && (is_cont || byte_i >= uld_pkg::ByteNoLead))) begin
      wr_o              = 1'b1;
      item_o.kind       = uld_pkg::KIND_ERR;
      item_o.code_point = {24'd0, byte_i};
      exp_d             = 1'b0;
      pv_d              = 32'd0;
      lm_d              = 32'd0;
    end else begin
      if (exp_q) begin
        pv_n = (pv_q << 6) + {26'd0, byte_i[5:0]};
        lm_n = lm_q << 5;
      end else begin
        pv_n = {24'd0, byte_i};
        lm_n = byte_i[7] ? uld_pkg::FirstMask : 32'd0;
      end
      exp_d = |(pv_n & lm_n);
      cp    = pv_n & ((lm_n << 1) - 32'd1);
      pv_d  = exp_d ? pv_n : cp;
      lm_d  = lm_n;
      if (!exp_d) begin
        wr_o = 1'b1;
        if (cp == uld_pkg::CodeAt) begin
          item_o.kind = uld_pkg::KIND_END;
        end else begin
          item_o.code_point = cp;
        end
      end
    end
    if (!accept_i) begin
      wr_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_br_q <= 1'b0;
      acc_q   <= 16'd0;
      exp_q   <= 1'b0;
      pv_q    <= 32'd0;
      lm_q    <= 32'd0;
    end else if (accept_i) begin
      in_br_q <= in_br_d;
      acc_q   <= acc_d;
      exp_q   <= exp_d;
      pv_q    <= pv_d;
      lm_q    <= lm_d;
    end
  end

endmodule

// ===== rtl/core/uld_fifo.sv =====
// short item queue between front and back
module uld_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  uld_pkg::item_t wr_item_i,
  output logic           full_o,
  input  logic           rd_i,
  output uld_pkg::item_t rd_item_o,
  output logic           empty_o
);

  uld_pkg::item_t mem_q [uld_pkg::FifoDepth];

  logic [uld_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [uld_pkg::FifoCntW-1:0] cnt_q;
  logic                         wr_en, rd_en;

  function automatic logic [uld_pkg::FifoPtrW-1:0] ptr_inc(
    input logic [uld_pkg::FifoPtrW-1:0] p
  );
    return (p == uld_pkg::FifoPtrW'(uld_pkg::FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o    = (cnt_q == uld_pkg::FifoCntW'(uld_pkg::FifoDepth));
  assign empty_o   = (cnt_q == '0);
  assign wr_en     = wr_i && !full_o;
  assign rd_en     = rd_i && !empty_o;
  assign rd_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (rd_en) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/uld_back.sv =====
// back end: label slot counting and the output register
`include "utf8_label_decoder_defines.svh"

module uld_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  uld_pkg::item_t q_item_i,
  output logic           q_rd_o,
  input  logic           pop_i,
  output logic           out_vld_o,
  output uld_pkg::item_t out_item_o
);

  logic                     out_vld_q, out_vld_d;
  uld_pkg::item_t           out_item_q;
  logic [uld_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     pop_ok, take, keep;

  assign pop_ok = pop_i && out_vld_q;
  assign take   = !q_empty_i && (!out_vld_q || pop_ok);
  assign q_rd_o = take;

  always_comb begin
    cnt_d     = cnt_q;
    keep      = 1'b1;
    out_vld_d = out_vld_q && !pop_ok;
    if (take) begin
      case (q_item_i.kind)
        uld_pkg::KIND_END: begin
          cnt_d = '0;
        end
        uld_pkg::KIND_CODE: begin
          if (cnt_q == uld_pkg::CntMax) begin
            keep = 1'b0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
      out_vld_d = keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_item_q <= q_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_item_o = out_item_q;

  `ULD_ASSERT(a_end_clears, (take && q_item_i.kind == uld_pkg::KIND_END) |=> (cnt_q == '0), "end item did not clear count")
  `ULD_ASSERT(a_full_drop, (take && q_item_i.kind == uld_pkg::KIND_CODE && cnt_q == uld_pkg::CntMax) |=> (!out_vld_q && cnt_q == uld_pkg::CntMax), "full label did not drop item")
  `ULD_ASSERT_ALWAYS(a_pop_drains, (rst_ni && pop_ok && !take) |=> !out_vld_q, "taken item still shown")

endmodule

// ===== rtl/core/utf8_label_decoder.sv =====
// top level of the utf-8 label decoder
//
//   channel   handshake            payload
//   input     push / full          byte_in_i
//   result    empty / pop          kind_o, code_point_o, picture_number_o
//
// one byte per cycle is taken while the two-entry queue has room.
// a result is queued, then registered. the back end drains one queued item
// per cycle unless empty and pop are low; dropped code points use that slot.
// full rises only while pop is held low long enough to fill the queue.
// reset clears all decoder state, the label count and the queue.
module utf8_label_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [31:0] code_point_o,
  output logic [15:0] picture_number_o
);

  logic           accept, fe_wr, q_empty, q_rd, out_vld;
  uld_pkg::item_t fe_item, q_item, out_item;

  assign accept = push && !full;

  uld_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (byte_in_i),
    .wr_o     (fe_wr),
    .item_o   (fe_item)
  );

  uld_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fe_wr),
    .wr_item_i (fe_item),
    .full_o    (full),
    .rd_i      (q_rd),
    .rd_item_o (q_item),
    .empty_o   (q_empty)
  );

  uld_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_item_i   (q_item),
    .q_rd_o     (q_rd),
    .pop_i      (pop),
    .out_vld_o  (out_vld),
    .out_item_o (out_item)
  );

  assign empty            = !out_vld;
  assign kind_o           = out_item.kind;
  assign code_point_o     = out_item.code_point;
  assign picture_number_o = out_item.picture;

endmodule
